/* rtl/rtd_pkg.sv */
// rtd_pkg: shared types and constants of the run-length text decoder.
// Depends on nothing; imported by rtd_front, rtd_back and rle_text_run_decoder.
`timescale 1ns / 1ps

package rtd_pkg;

  localparam int unsigned CharW             = 8;
  localparam int unsigned DigitW            = 4;
  localparam int unsigned RunCountW         = 16;
  localparam int unsigned CountWidthDefault = 16;
  localparam int unsigned QueueDepth        = 2;

  localparam logic [CharW-1:0] DigitLow  = 8'h30;
  localparam logic [CharW-1:0] DigitHigh = 8'h39;

  // classified input beat, front to back
  typedef struct packed {
    logic [CharW-1:0]  symbol;
    logic [DigitW-1:0] digit;
    logic              is_digit;
    logic              last;
  } rtd_cls_t;

  // finished run, back to result queue
  typedef struct packed {
    logic [CharW-1:0]     symbol;
    logic [RunCountW-1:0] count;
    logic                 overflow;
    logic                 final_run;
  } rtd_run_t;

endpackage

/* rtl/rtd_fifo.sv */
// rtd_fifo: small register queue used between front and back and for results.
// Depends on nothing outside itself.
`timescale 1ns / 1ps

module rtd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  output logic [Width-1:0] rd_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = wr_en_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = rd_en_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en_i && !rd_en_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!wr_en_i && rd_en_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rd_ptr_q];
  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);

endmodule

/* rtl/rtd_front.sv */
// rtd_front: accepts input bytes and classifies them as digit or symbol.
// Depends on rtd_pkg.
`timescale 1ns / 1ps

module rtd_front import rtd_pkg::*; (
  input  logic             push_i,
  input  logic             full_i,
  input  logic [CharW-1:0] char_in_i,
  input  logic             end_of_text_i,
  output logic             wr_en_o,
  output rtd_cls_t         cls_o
);

  logic [CharW-1:0] offs;

  assign offs    = char_in_i - DigitLow;
  assign wr_en_o = push_i && !full_i;

  always_comb begin
    cls_o          = '0;
    cls_o.symbol   = char_in_i;
    cls_o.digit    = offs[DigitW-1:0];
    cls_o.is_digit = (char_in_i inside {[DigitLow:DigitHigh]});
    cls_o.last     = end_of_text_i;
  end

endmodule

/* rtl/rtd_back.sv */
// rtd_back: run state, saturating decimal count and run emission.
// Depends on rtd_pkg.
`timescale 1ns / 1ps

module rtd_back import rtd_pkg::*; #(
  parameter int unsigned CountWidth = CountWidthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  rtd_cls_t cls_i,
  output logic     rd_en_o,
  input  logic     out_full_i,
  output logic     out_wr_o,
  output rtd_run_t run_o
);

  localparam int unsigned CntW = (CountWidth > RunCountW) ? RunCountW : CountWidth;
  localparam int unsigned VW   = CntW + 4;

  logic [CharW-1:0] sym_q, sym_d;
  logic [CntW-1:0]  cnt_q, cnt_d, cnt_acc;
  logic             held_q, held_d, sat_q, sat_d, sat_acc;
  logic [VW-1:0]    prod;
  logic             fire, ovf;

  assign fire    = valid_i && !out_full_i;
  assign rd_en_o = fire;

  assign prod    = ({4'b0, cnt_q} << 3) + ({4'b0, cnt_q} << 1) + VW'(cls_i.digit);
  assign ovf     = |prod[VW-1:CntW];
  assign cnt_acc = ovf ? '1 : prod[CntW-1:0];
  assign sat_acc = sat_q || ovf;

  always_comb begin
    sym_d    = sym_q;
    cnt_d    = cnt_q;
    held_d   = held_q;
    sat_d    = sat_q;
    out_wr_o = 1'b0;
    run_o    = '0;
    run_o.final_run = cls_i.last;
    if (fire) begin
      if (held_q && cls_i.is_digit) begin
        cnt_d = cnt_acc;
        sat_d = sat_acc;
        if (cls_i.last) begin
          out_wr_o = 1'b1;
          if (cnt_acc != '0) begin
            run_o.symbol   = sym_q;
            run_o.count    = RunCountW'(cnt_acc);
            run_o.overflow = sat_acc;
          end
        end
      end else begin
        if (held_q && cnt_q != '0) begin
          out_wr_o       = 1'b1;
          run_o.symbol   = sym_q;
          run_o.count    = RunCountW'(cnt_q);
          run_o.overflow = sat_q;
        end else if (cls_i.last) begin
          out_wr_o = 1'b1;
        end
        sym_d  = cls_i.symbol;
        cnt_d  = '0;
        sat_d  = 1'b0;
        held_d = 1'b1;
      end
      if (cls_i.last) begin
        sym_d  = '0;
        cnt_d  = '0;
        sat_d  = 1'b0;
        held_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q  <= '0;
      cnt_q  <= '0;
      held_q <= 1'b0;
      sat_q  <= 1'b0;
    end else begin
      sym_q  <= sym_d;
      cnt_q  <= cnt_d;
      held_q <= held_d;
      sat_q  <= sat_d;
    end
  end

endmodule

/* rtl/rle_text_run_decoder.sv */
// rle_text_run_decoder: top level of the run-length text decoder.
// Depends on rtd_pkg, rtd_front, rtd_back and rtd_fifo.
//
// Input side is a queue write port: a byte beat (char_in_i, end_of_text_i)
// is taken at a clock edge with push high and full low. Result side is a
// queue read port: while empty is low the oldest run sits on run_symbol_o,
// run_count_o, count_overflow_o and final_run_o; pop with empty low takes it.
// Each byte yields zero or one run; the byte flagged end_of_text always
// yields exactly one run with final_run_o set (symbol 0, count 0 if nothing
// was left to close) and returns the parser to its idle state.
// Throughput: one byte per cycle while the result queue has room, set by the
// single count update (count*10 + digit, saturating) in the back end.
// A run closed by a byte goes from the two-entry classify queue through the
// back end, is written into the two-entry result queue and is then on the
// result ports, where it can be popped.
// When the receiver stops popping, the result queue fills, the back end
// halts, and full rises once the classify queue holds two bytes.
// Reset empties both queues and clears the run state.
`timescale 1ns / 1ps

module rle_text_run_decoder import rtd_pkg::*; #(
  parameter int unsigned CountWidth = CountWidthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [CharW-1:0] char_in_i,
  input  logic             end_of_text_i,
  output logic             empty,
  input  logic             pop,
  output logic [CharW-1:0] run_symbol_o,
  output logic [RunCountW-1:0] run_count_o,
  output logic             count_overflow_o,
  output logic             final_run_o
);

  localparam int unsigned CntW = (CountWidth > RunCountW) ? RunCountW : CountWidth;
  localparam logic [RunCountW-1:0] CountLimit = RunCountW'({CntW{1'b1}});

  rtd_cls_t cls_in, cls_out;
  rtd_run_t run_in, run_out;
  logic     cls_wr, cls_rd, cls_empty;
  logic     run_wr, run_full;

  rtd_front u_front (
    .push_i        (push),
    .full_i        (full),
    .char_in_i     (char_in_i),
    .end_of_text_i (end_of_text_i),
    .wr_en_o       (cls_wr),
    .cls_o         (cls_in)
  );

  rtd_fifo #(
    .Width ($bits(rtd_cls_t)),
    .Depth (QueueDepth)
  ) u_cls_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cls_wr),
    .wr_data_i (cls_in),
    .rd_en_i   (cls_rd),
    .rd_data_o (cls_out),
    .full_o    (full),
    .empty_o   (cls_empty)
  );

  rtd_back #(
    .CountWidth (CountWidth)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (!cls_empty),
    .cls_i      (cls_out),
    .rd_en_o    (cls_rd),
    .out_full_i (run_full),
    .out_wr_o   (run_wr),
    .run_o      (run_in)
  );

  rtd_fifo #(
    .Width ($bits(rtd_run_t)),
    .Depth (QueueDepth)
  ) u_run_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (run_wr),
    .wr_data_i (run_in),
    .rd_en_i   (pop && !empty),
    .rd_data_o (run_out),
    .full_o    (run_full),
    .empty_o   (empty)
  );

  assign run_symbol_o     = run_out.symbol;
  assign run_count_o      = run_out.count;
  assign count_overflow_o = run_out.overflow;
  assign final_run_o      = run_out.final_run;

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_wr |-> !run_full) else $error("result queue overrun");

  a_marker_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && final_run_o && run_count_o == '0) |-> (run_symbol_o == '0 && !count_overflow_o))
    else $error("end marker carries data");

  a_mid_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !final_run_o) |-> (run_count_o != '0)) else $error("zero run emitted");

  a_overflow_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && count_overflow_o) |-> (run_count_o == CountLimit))
    else $error("saturated count below limit");

endmodule
